// ===== rtl/fifo_job_dispatcher_macros.svh =====
// Assertion macros used by the file that checks the dispatcher.
`ifndef FIFO_JOB_DISPATCHER_MACROS_SVH
`define FIFO_JOB_DISPATCHER_MACROS_SVH

// Property sampled on the rising clock, switched off while reset is held.
`define FJD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check, but also sampled during reset.
`define FJD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/fjd_pkg.sv =====
package fjd_pkg;

  // Default sizes of the server pool, the wait queue and the job id.
  localparam int unsigned MAX_SERVERS_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_WIDTH_DEF    = 16;

  // Fixed widths of the register and of the beat fields.
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned SERVER_W = 3;
  localparam int unsigned JOB_ID_W = 16;
  localparam int unsigned FREE_W   = 4;
  localparam int unsigned WAIT_W   = 5;

  // Number of active servers after reset.
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd3;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_INDEX    = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_QUEUE_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    OP_ARRIVAL  = 1'b0,
    OP_COMPLETE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_ASSIGN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic event_en;   // apply the accepted event
    logic read_en;    // read the queue head and rank the free servers
    logic assign_en;  // dispatch the head job and load the result beat
  } cmd_t;

endpackage

// ===== rtl/fjd_ctrl.sv =====
module fjd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output fjd_pkg::cmd_t cmd_o
);

  fjd_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            slot_free;

  // The result register may be reloaded once its beat is gone or leaves now.
  assign slot_free = !out_valid_q || !out_stall_i;
  assign accept    = in_valid_i && (state_q == fjd_pkg::S_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      fjd_pkg::S_IDLE: begin
        if (accept) begin
          state_d = fjd_pkg::S_READ;
        end
      end
      fjd_pkg::S_READ: begin
        state_d = fjd_pkg::S_ASSIGN;
      end
      fjd_pkg::S_ASSIGN: begin
        if (slot_free) begin
          state_d = fjd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fjd_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_stall_o      = 1'b1;
    cmd_o.event_en  = 1'b0;
    cmd_o.read_en   = 1'b0;
    cmd_o.assign_en = 1'b0;
    case (state_q)
      fjd_pkg::S_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.event_en = accept;
      end
      fjd_pkg::S_READ: begin
        cmd_o.read_en = 1'b1;
      end
      fjd_pkg::S_ASSIGN: begin
        cmd_o.assign_en = slot_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // The result beat stays valid until the receiver takes it.
  always_comb begin
    if (cmd_o.assign_en) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fjd_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/fjd_dp.sv =====
module fjd_dp #(
  parameter int unsigned MAX_SERVERS = fjd_pkg::MAX_SERVERS_DEF,
  parameter int unsigned QUEUE_DEPTH = fjd_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_WIDTH    = fjd_pkg::ID_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fjd_pkg::cmd_t                 cmd_i,
  input  logic                          cfg_we_i,
  input  logic [fjd_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          operation_i,
  input  logic [fjd_pkg::SERVER_W-1:0]  server_index_i,
  output logic [1:0]                    status_o,
  output logic                          assigned_o,
  output logic [fjd_pkg::JOB_ID_W-1:0]  assigned_job_id_o,
  output logic [fjd_pkg::SERVER_W-1:0]  assigned_server_o,
  output logic [fjd_pkg::FREE_W-1:0]    free_servers_o,
  output logic [fjd_pkg::WAIT_W-1:0]    waiting_jobs_o
);

  localparam int unsigned SRV_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned FCNT_W = $clog2(MAX_SERVERS + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // Architectural state.
  logic [fjd_pkg::CFG_W-1:0] cfg_q, cfg_d;
  logic [MAX_SERVERS-1:0]    busy_q, busy_d;
  logic [PTR_W-1:0]          head_q, head_d;
  logic [PTR_W-1:0]          tail_q, tail_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [ID_WIDTH-1:0]       next_id_q, next_id_d;
  fjd_pkg::status_e          status_q, status_d;

  // Wait queue storage and its registered head read.
  logic [ID_WIDTH-1:0]       queue_mem [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0]       head_data_q;

  // Free-server ranking taken in the read cycle.
  logic [SRV_W-1:0]          first_q, first_d;
  logic                      any_free_q, any_free_d;
  logic [FCNT_W-1:0]         free_cnt_q, free_cnt_d;

  // Result beat registers.
  fjd_pkg::status_e          out_status_q;
  logic                      out_assigned_q;
  logic [ID_WIDTH-1:0]       out_job_q;
  logic [SRV_W-1:0]          out_server_q;
  logic [FCNT_W-1:0]         out_free_q;
  logic [CNT_W-1:0]          out_wait_q;

  logic [MAX_SERVERS-1:0]    active_mask;
  logic [MAX_SERVERS-1:0]    idx_sel;
  logic [MAX_SERVERS-1:0]    free_mask;
  logic                      idx_valid;
  logic                      idx_busy;
  logic                      queue_full;
  logic                      push;
  logic                      do_assign;

  // Servers below the configured count are active; the index decodes to one server.
  always_comb begin
    for (int i = 0; i < MAX_SERVERS; i++) begin
      active_mask[i] = 32'(cfg_q) > 32'(i);
      idx_sel[i]     = 32'(server_index_i) == 32'(i);
    end
  end

  assign idx_valid  = |(idx_sel & active_mask);
  assign idx_busy   = |(idx_sel & busy_q);
  assign queue_full = (cnt_q == CNT_FULL);
  assign push       = cmd_i.event_en && (operation_i == fjd_pkg::OP_ARRIVAL) && !queue_full;
  assign free_mask  = active_mask & ~busy_q;
  assign do_assign  = cmd_i.assign_en && (cnt_q != '0) && any_free_q;

  // Rank the free servers: lowest index first, and how many there are.
  always_comb begin
    first_d    = '0;
    free_cnt_d = '0;
    for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        first_d = SRV_W'(i);
      end
    end
    for (int i = 0; i < MAX_SERVERS; i++) begin
      free_cnt_d = free_cnt_d + FCNT_W'(free_mask[i]);
    end
    any_free_d = |free_mask;
  end

  // Next values of the config register, the queue, the busy bits, the job id and the event status.
  always_comb begin
    cfg_d     = cfg_q;
    busy_d    = busy_q;
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    next_id_d = next_id_q;
    status_d  = status_q;
    if (cfg_we_i) begin
      cfg_d = cfg_wdata_i;
    end
    if (cmd_i.event_en) begin
      status_d = fjd_pkg::ST_OK;
      if (operation_i == fjd_pkg::OP_ARRIVAL) begin
        if (queue_full) begin
          status_d = fjd_pkg::ST_QUEUE_FULL;
        end else begin
          tail_d    = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
          cnt_d     = cnt_q + CNT_W'(1);
          next_id_d = next_id_q + ID_WIDTH'(1);
        end
      end else if (!idx_valid) begin
        status_d = fjd_pkg::ST_BAD_INDEX;
      end else if (!idx_busy) begin
        status_d = fjd_pkg::ST_ALREADY_FREE;
      end else begin
        busy_d = busy_q & ~idx_sel;
      end
    end
    if (do_assign) begin
      head_d          = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
      cnt_d           = cnt_q - CNT_W'(1);
      busy_d[first_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= fjd_pkg::ACTIVE_RESET;
      busy_q    <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      cnt_q     <= '0;
      next_id_q <= ID_WIDTH'(1);
    end else begin
      cfg_q     <= cfg_d;
      busy_q    <= busy_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      cnt_q     <= cnt_d;
      next_id_q <= next_id_d;
    end
  end

  // Queue memory: one write port at the tail, one registered read at the head.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_mem[tail_q] <= next_id_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_en) begin
      head_data_q <= queue_mem[head_q];
    end
  end

  // Event status and the server ranking are held until the result is built.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (cmd_i.read_en) begin
      first_q    <= first_d;
      any_free_q <= any_free_d;
      free_cnt_q <= free_cnt_d;
    end
  end

  // Load the result beat; it holds while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (cmd_i.assign_en) begin
      out_status_q   <= status_q;
      out_assigned_q <= do_assign;
      out_job_q      <= do_assign ? head_data_q : '0;
      out_server_q   <= do_assign ? first_q : '0;
      out_free_q     <= free_cnt_q - FCNT_W'(do_assign);
      out_wait_q     <= cnt_q - CNT_W'(do_assign);
    end
  end

  assign status_o          = out_status_q;
  assign assigned_o        = out_assigned_q;
  assign assigned_job_id_o = fjd_pkg::JOB_ID_W'(out_job_q);
  assign assigned_server_o = fjd_pkg::SERVER_W'(out_server_q);
  assign free_servers_o    = fjd_pkg::FREE_W'(out_free_q);
  assign waiting_jobs_o    = fjd_pkg::WAIT_W'(out_wait_q);

endmodule

// ===== rtl/fifo_job_dispatcher.sv =====
// Job dispatcher with a pool of servers and a FIFO of waiting jobs. Each input beat is either a
// job arrival, which takes the next job id (starting at 1, wrapping) and queues it, or a server
// completion, which frees that server. After every event the head job goes to the lowest-numbered
// free active server, and one result beat reports the status, any assignment, the free-server
// count and the waiting count. An arrival into a full queue is dropped with a status code. Each
// item passes through three steps: the accept step applies the event and pushes the queue, the
// read step reads the queue-head memory and ranks the free servers, the assign step dispatches
// and loads the result register. The next beat is accepted once the last has left the assign step;
// a stalled result holds that step until the previous beat is taken. The active server count resets
// to three; the user must write it through cfg_we_i only while idle, which the block does not enforce.
`include "fifo_job_dispatcher_macros.svh"

module fifo_job_dispatcher #(
  parameter int unsigned MAX_SERVERS = fjd_pkg::MAX_SERVERS_DEF,
  parameter int unsigned QUEUE_DEPTH = fjd_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_WIDTH    = fjd_pkg::ID_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fjd_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [fjd_pkg::SERVER_W-1:0]  server_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic                          assigned_o,
  output logic [fjd_pkg::JOB_ID_W-1:0]  assigned_job_id_o,
  output logic [fjd_pkg::SERVER_W-1:0]  assigned_server_o,
  output logic [fjd_pkg::FREE_W-1:0]    free_servers_o,
  output logic [fjd_pkg::WAIT_W-1:0]    waiting_jobs_o
);

  fjd_pkg::cmd_t cmd;

  // Sequencer for the three steps of each item.
  fjd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Queue, busy bits, job id counter and result register.
  fjd_dp #(
    .MAX_SERVERS (MAX_SERVERS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .operation_i       (operation_i),
    .server_index_i    (server_index_i),
    .status_o          (status_o),
    .assigned_o        (assigned_o),
    .assigned_job_id_o (assigned_job_id_o),
    .assigned_server_o (assigned_server_o),
    .free_servers_o    (free_servers_o),
    .waiting_jobs_o    (waiting_jobs_o)
  );

  // An accepted beat keeps the input stalled while it is worked on.
  `FJD_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "accepted twice in a row")

  // Without an assignment the job id and server fields are zero.
  `FJD_ASSERT(a_no_assign_zero, out_valid_o && !assigned_o |-> assigned_job_id_o == '0 && assigned_server_o == '0, "stale assignment fields")

  // The waiting count never exceeds the queue depth.
  `FJD_ASSERT(a_wait_bound, out_valid_o |-> waiting_jobs_o <= QUEUE_DEPTH, "waiting count beyond queue depth")

  // In the cycle after reset is seen low, no result beat is pending.
  `FJD_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "result valid in reset")

endmodule

// ===== test/fifo_job_dispatcher_tb.sv =====
module fifo_job_dispatcher_tb;

  localparam int unsigned POOL_SIZE      = fjd_pkg::MAX_SERVERS_DEF;
  localparam int unsigned QUEUE_SLOTS    = fjd_pkg::QUEUE_DEPTH_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned PHASE_BEATS    = 50;

  // One expected result beat, laid out like the output ports.
  typedef struct packed {
    fjd_pkg::status_e               status;
    logic                           assigned;
    logic [fjd_pkg::JOB_ID_W-1:0]   job_id;
    logic [fjd_pkg::SERVER_W-1:0]   server;
    logic [fjd_pkg::FREE_W-1:0]     free_cnt;
    logic [fjd_pkg::WAIT_W-1:0]     wait_cnt;
  } dispatch_t;

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          cfg_we_i       = 1'b0;
  logic [fjd_pkg::CFG_W-1:0]     cfg_wdata_i    = '0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_stall_o;
  logic                          operation_i    = 1'b0;
  logic [fjd_pkg::SERVER_W-1:0]  server_index_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i    = 1'b0;
  logic [1:0]                    status_o;
  logic                          assigned_o;
  logic [fjd_pkg::JOB_ID_W-1:0]  assigned_job_id_o;
  logic [fjd_pkg::SERVER_W-1:0]  assigned_server_o;
  logic [fjd_pkg::FREE_W-1:0]    free_servers_o;
  logic [fjd_pkg::WAIT_W-1:0]    waiting_jobs_o;

  // Shadow copy of the dispatcher state.
  logic [POOL_SIZE-1:0]          pool_busy   = '0;
  logic [fjd_pkg::JOB_ID_W-1:0]  waiting_ids[$];
  logic [fjd_pkg::JOB_ID_W-1:0]  next_job_id = fjd_pkg::JOB_ID_W'(1);
  logic [fjd_pkg::CFG_W-1:0]     pool_active = fjd_pkg::ACTIVE_RESET;
  dispatch_t                     dispatch_expected[$];

  int unsigned error_count  = 0;
  int unsigned idle_cycles  = 0;
  int unsigned hold_left    = 0;
  int unsigned rx_gap_left  = 0;
  bit          hold_request = 1'b0;
  bit          tx_idle_en   = 1'b0;
  bit          rx_idle_en   = 1'b0;

  fifo_job_dispatcher uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .server_index_i    (server_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .assigned_o        (assigned_o),
    .assigned_job_id_o (assigned_job_id_o),
    .assigned_server_o (assigned_server_o),
    .free_servers_o    (free_servers_o),
    .waiting_jobs_o    (waiting_jobs_o)
  );

  always #5 clk_i = ~clk_i;

  // Number of servers that count, with oversized settings clamped to the pool.
  function automatic int unsigned active_limit();
    return (pool_active > POOL_SIZE) ? POOL_SIZE : pool_active;
  endfunction

  // Idle length: mostly short, now and then a long stretch.
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Applies one job event to the shadow state and returns the beat it should produce.
  function automatic dispatch_t dispatch_event(fjd_pkg::op_e op,
                                               logic [fjd_pkg::SERVER_W-1:0] idx);
    dispatch_t   r;
    int unsigned lim;
    int unsigned s;
    lim        = active_limit();
    r.status   = fjd_pkg::ST_OK;
    r.assigned = 1'b0;
    r.job_id   = '0;
    r.server   = '0;
    r.free_cnt = '0;
    r.wait_cnt = '0;
    if (op == fjd_pkg::OP_ARRIVAL) begin
      if (waiting_ids.size() >= QUEUE_SLOTS) begin
        r.status = fjd_pkg::ST_QUEUE_FULL;
      end else begin
        waiting_ids.push_back(next_job_id);
        next_job_id = next_job_id + fjd_pkg::JOB_ID_W'(1);
      end
    end else begin
      if (idx >= lim) begin
        r.status = fjd_pkg::ST_BAD_INDEX;
      end else if (!pool_busy[idx]) begin
        r.status = fjd_pkg::ST_ALREADY_FREE;
      end else begin
        pool_busy[idx] = 1'b0;
      end
    end
    // The head job goes to the lowest free active server, even after an error.
    if (waiting_ids.size() > 0) begin
      for (s = 0; s < lim && !r.assigned; s++) begin
        if (!pool_busy[s]) begin
          r.job_id     = waiting_ids.pop_front();
          r.server     = fjd_pkg::SERVER_W'(s);
          r.assigned   = 1'b1;
          pool_busy[s] = 1'b1;
        end
      end
    end
    for (s = 0; s < lim; s++) begin
      if (!pool_busy[s]) r.free_cnt = r.free_cnt + fjd_pkg::FREE_W'(1);
    end
    r.wait_cnt = fjd_pkg::WAIT_W'(waiting_ids.size());
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Result beats are checked first, then register writes and accepted events update the shadow.
  always @(posedge clk_i) begin : result_check
    dispatch_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (dispatch_expected.size() == 0) begin
          $error("result beat arrived with no job event pending");
          error_count++;
        end else begin
          exp_r = dispatch_expected.pop_front();
          check_field("status", 32'(exp_r.status), 32'(status_o));
          check_field("assigned", 32'(exp_r.assigned), 32'(assigned_o));
          check_field("assigned_job_id", 32'(exp_r.job_id), 32'(assigned_job_id_o));
          check_field("assigned_server", 32'(exp_r.server), 32'(assigned_server_o));
          check_field("free_servers", 32'(exp_r.free_cnt), 32'(free_servers_o));
          check_field("waiting_jobs", 32'(exp_r.wait_cnt), 32'(waiting_jobs_o));
        end
      end
      if (cfg_we_i) pool_active = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        dispatch_expected.push_back(dispatch_event(fjd_pkg::op_e'(operation_i),
                                                   server_index_i));
      end
    end
  end

  // Output stall: a requested long hold-off, else random gaps when enabled.
  always @(posedge clk_i) begin : result_stall
    logic stall_nxt;
    stall_nxt = 1'b0;
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_nxt = 1'b1;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      stall_nxt = 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
      rx_gap_left = pick_gap() - 1;
      stall_nxt   = 1'b1;
    end
    out_stall_i <= stall_nxt;
  end

  // Count cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Offers one event beat and returns at the edge where it is taken, or after the idle gap that
  // follows it. Valid stays high unless an idle gap follows, so back-to-back calls stream without a bubble.
  task automatic send_job_event(input fjd_pkg::op_e op,
                                input logic [fjd_pkg::SERVER_W-1:0] idx);
    int unsigned gap;
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    server_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_arrival();
    send_job_event(fjd_pkg::OP_ARRIVAL, fjd_pkg::SERVER_W'($urandom_range(0, POOL_SIZE - 1)));
  endtask

  // Stop offering events and wait until every expected beat has been taken.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (dispatch_expected.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_active_servers(input logic [fjd_pkg::CFG_W-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Reset defaults: error codes, filling the three servers, queuing and handing off.
  task automatic test_directed_basics();
    send_job_event(fjd_pkg::OP_COMPLETE, 3'd0);
    send_job_event(fjd_pkg::OP_COMPLETE, 3'd7);
    send_job_event(fjd_pkg::OP_COMPLETE, 3'd3);
    repeat (4) send_arrival();
    send_job_event(fjd_pkg::OP_COMPLETE, 3'd1);
    send_job_event(fjd_pkg::OP_COMPLETE, 3'd2);
    send_job_event(fjd_pkg::OP_COMPLETE, 3'd2);
  endtask

  // Zero, oversized and shrinking settings, including busy servers left outside the range.
  task automatic test_register_extremes();
    set_active_servers(4'd0);
    send_arrival();
    send_arrival();
    send_job_event(fjd_pkg::OP_COMPLETE, 3'd0);
    // Raising the count lets waiting jobs go out one per beat.
    set_active_servers(4'd15);
    send_job_event(fjd_pkg::OP_COMPLETE, 3'd6);
    send_job_event(fjd_pkg::OP_COMPLETE, 3'd7);
    set_active_servers(4'd8);
    repeat (8) send_arrival();
    // Server five stays busy while hidden and can be freed once it is back in range.
    set_active_servers(4'd4);
    send_job_event(fjd_pkg::OP_COMPLETE, 3'd5);
    send_job_event(fjd_pkg::OP_COMPLETE, 3'd3);
    set_active_servers(4'd8);
    send_job_event(fjd_pkg::OP_COMPLETE, 3'd5);
  endtask

  // A long output hold while arrivals keep coming: the block backs up and the queue overflows.
  task automatic test_backpressure_queue_full();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_active_servers(4'd1);
    hold_request = 1'b1;
    repeat (QUEUE_SLOTS + 6) send_arrival();
    repeat (4) send_job_event(fjd_pkg::OP_COMPLETE, 3'd0);
  endtask

  // Mostly sensible traffic across several settings, with bursts and some noise.
  task automatic test_random_traffic();
    logic [fjd_pkg::CFG_W-1:0] settings[8];
    int unsigned               ph;
    int unsigned               sent;
    int unsigned               roll;
    int unsigned               s;
    int unsigned               busy_list[$];
    settings = '{4'd3, 4'd8, 4'd1, 4'd0, 4'd15, 4'd5, 4'd2, 4'd9};
    for (ph = 0; ph < 8; ph++) begin
      set_active_servers(settings[ph]);
      tx_idle_en = (ph % 4 != 2);
      rx_idle_en = (ph % 3 != 1);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          send_job_event(fjd_pkg::op_e'($urandom_range(0, 1)),
                         fjd_pkg::SERVER_W'($urandom_range(0, POOL_SIZE - 1)));
          sent++;
        end else if (roll < 14) begin
          repeat (6) send_arrival();
          sent += 6;
        end else if (roll < 55) begin
          send_arrival();
          sent++;
        end else begin
          // Free a server that is actually busy when there is one.
          busy_list.delete();
          for (s = 0; s < active_limit(); s++) begin
            if (pool_busy[s]) busy_list.push_back(s);
          end
          if (busy_list.size() == 0) begin
            send_job_event(fjd_pkg::OP_COMPLETE,
                           fjd_pkg::SERVER_W'($urandom_range(0, POOL_SIZE - 1)));
          end else begin
            send_job_event(fjd_pkg::OP_COMPLETE,
                           fjd_pkg::SERVER_W'(busy_list[$urandom_range(0,
                                                         busy_list.size() - 1)]));
          end
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_basics();
    test_register_extremes();
    test_backpressure_queue_full();
    test_random_traffic();
    drain_results();
    repeat (5) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fjd_pkg.sv
rtl/fjd_ctrl.sv
rtl/fjd_dp.sv
rtl/fifo_job_dispatcher.sv
test/fifo_job_dispatcher_tb.sv
